// ===== src/kpfh_pkg.sv =====
// Package with shared types, constants and the hash step for the k-mer pair feature hasher.
package kpfh_pkg;

  localparam int MAX_LEN_DEF = 1024;
  localparam int RAD_MAX = 3;
  localparam int DIST_MAX = 7;
  localparam int RAD_CNT = RAD_MAX + 1;
  localparam logic [31:0] HASH_SEED = 32'hAAAAAAAA;
  localparam logic [31:0] MASK_RESET = 32'h7FFFFFFF;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_DISTANCE = 2'd1;
  localparam logic [1:0] REG_MASK = 2'd2;

  typedef struct packed {
    logic [1:0]  radius_limit;
    logic [2:0]  distance_limit;
    logic [31:0] hash_mask;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRC_RD,
    ST_SRC_HS,
    ST_DST_RD,
    ST_DST_HS,
    ST_TUP,
    ST_EMIT
  } state_t;

  function automatic logic [31:0] hash_step(logic [31:0] h, logic odd, logic [31:0] v);
    logic [31:0] p;
    p = v * (h >> 3);
    if (!odd) begin
      return h ^ ((h << 7) ^ p);
    end
    return h ^ ~(((h << 11) + v) ^ (h >> 5));
  endfunction

endpackage

// ===== src/kpfh_seq_mem.sv =====
// Sequence character memory with one write port and one registered read port.
module kpfh_seq_mem #(
  parameter int DEPTH = kpfh_pkg::MAX_LEN_DEF,
  parameter int ADDR_W = $clog2(kpfh_pkg::MAX_LEN_DEF)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/kpfh_cfg.sv =====
// APB-style configuration registers of the k-mer pair feature hasher.
module kpfh_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output kpfh_pkg::cfg_t cfg
);

  import kpfh_pkg::*;

  logic       wr;
  logic [1:0] reg_idx;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radius_limit <= '0;
      cfg.distance_limit <= '0;
      cfg.hash_mask <= MASK_RESET;
    end else if (wr) begin
      case (reg_idx)
        REG_RADIUS: cfg.radius_limit <= pwdata[1:0];
        REG_DISTANCE: cfg.distance_limit <= pwdata[2:0];
        REG_MASK: cfg.hash_mask <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RADIUS: prdata = {30'd0, cfg.radius_limit};
      REG_DISTANCE: prdata = {29'd0, cfg.distance_limit};
      REG_MASK: prdata = cfg.hash_mask;
      default: prdata = '0;
    endcase
  end

endmodule

// ===== src/kmer_pair_feature_hasher.sv =====
// Top level of the k-mer pair feature hasher: sequencer, hash datapath and output register.
//
// Channel   Direction  Contents
// s_axis    in         tuser: opcode; tdata: position, char_value, seq_length
// m_axis    out        tuser: context_only; tdata: feature_code, radius_index, distance_index;
//                      tlast: last
// APB       in/out     radius_limit, distance_limit, hash_mask
//
// A write word is stored when it is taken. A query first hashes the source codes for every radius
// and, per (r,d) pair, reads and hashes the destination characters, computes two tuple hashes
// and loads two output words; the single memory read port and the shared hash step serialize it.
// Reset clears the state, output valid and config registers; datapath and memory hold no reset.
// A stalled output holds the sequencer in its emit state; new words are taken only when idle.
module kmer_pair_feature_hasher #(
  parameter int MAX_LEN = kpfh_pkg::MAX_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // position[9:0], char_value[17:10], seq_length[28:18]
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // feature_code[31:0], radius_index[33:32],
                                      // distance_index[36:34]
  output logic        m_axis_tuser,   // context_only
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import kpfh_pkg::*;

  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = ((LEN_W > 11) ? LEN_W : 11) + 1;

  cfg_t cfg;
  state_t state, state_next;

  logic [IDX_W-1:0] pos_q, len_q, base, idx;
  logic [31:0] mask_q, h_q, h_next, t_code, hv, lo, hi, s_code;
  logic [1:0] rmax_q, r_q, k_q, j_q;
  logic [2:0] dmax_q, d_q;
  logic sel_q, in_range, accept, out_free, pair_last;
  logic [31:0] start_code [RAD_CNT];
  logic [7:0] rd_char;
  logic mem_rd_en, mem_wr_en;
  logic [9:0] in_pos;
  logic [7:0] in_char;
  logic [10:0] in_len;
  logic [IDX_W-1:0] in_len_x, dest, len_m1;
  logic [1:0] rmax_c;
  logic [2:0] dmax_c;

  kpfh_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  assign in_pos = s_axis_tdata[9:0];
  assign in_char = s_axis_tdata[17:10];
  assign in_len = s_axis_tdata[28:18];
  assign in_len_x = IDX_W'(in_len);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign rmax_c = (32'(cfg.radius_limit) > RAD_MAX) ? 2'(RAD_MAX) : cfg.radius_limit;
  assign dmax_c = (32'(cfg.distance_limit) > DIST_MAX) ? 3'(DIST_MAX) : cfg.distance_limit;

  assign dest = pos_q + IDX_W'(d_q);
  assign len_m1 = len_q - IDX_W'(1);
  assign base = (state == ST_SRC_RD || state == ST_SRC_HS) ? pos_q :
                ((len_q != '0 && dest > len_m1) ? len_m1 : dest);
  assign idx = base + IDX_W'(k_q);
  assign in_range = idx < len_q;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign pair_last = (r_q == rmax_q) && (d_q == dmax_q);
  assign s_code = start_code[r_q];
  assign lo = (s_code < t_code) ? s_code : t_code;
  assign hi = (s_code < t_code) ? t_code : s_code;

  kpfh_seq_mem #(.DEPTH(MAX_LEN), .ADDR_W(ADDR_W)) u_mem (
    .clk(clk), .wr_en(mem_wr_en), .wr_addr(ADDR_W'(in_pos)), .wr_data(in_char),
    .rd_en(mem_rd_en), .rd_addr(idx[ADDR_W-1:0]), .rd_data(rd_char)
  );

  always_comb begin
    case (j_q)
      2'd0: hv = {30'd0, r_q};
      2'd1: hv = {29'd0, d_q};
      2'd2: hv = sel_q ? 32'd0 : lo;
      default: hv = sel_q ? t_code : hi;
    endcase
    if (state == ST_TUP) begin
      h_next = hash_step(h_q, j_q[0], hv);
    end else begin
      h_next = hash_step(h_q, idx[0], {{24{rd_char[7]}}, rd_char});
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept && s_axis_tuser == OP_QUERY) state_next = ST_SRC_RD;
      ST_SRC_RD: begin
        if (in_range) state_next = ST_SRC_HS;
        else if (k_q == rmax_q) state_next = ST_DST_RD;
      end
      ST_SRC_HS: state_next = (k_q == rmax_q) ? ST_DST_RD : ST_SRC_RD;
      ST_DST_RD: state_next = in_range ? ST_DST_HS : ST_TUP;
      ST_DST_HS: state_next = (k_q == r_q) ? ST_TUP : ST_DST_RD;
      ST_TUP: if (j_q == 2'd3) state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          if (!sel_q) state_next = ST_TUP;
          else state_next = pair_last ? ST_IDLE : ST_DST_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    mem_rd_en = (state == ST_SRC_RD || state == ST_DST_RD) && in_range;
    mem_wr_en = accept && (s_axis_tuser == OP_WRITE) && (32'(in_pos) < MAX_LEN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_EMIT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        pos_q <= IDX_W'(in_pos);
        len_q <= (in_len_x > IDX_W'(MAX_LEN)) ? IDX_W'(MAX_LEN) : in_len_x;
        rmax_q <= rmax_c;
        dmax_q <= dmax_c;
        mask_q <= cfg.hash_mask;
        k_q <= '0;
        r_q <= '0;
        d_q <= '0;
        h_q <= HASH_SEED;
      end
      ST_SRC_RD: begin
        if (!in_range) begin
          start_code[k_q] <= '0;
          if (k_q == rmax_q) begin
            k_q <= '0;
            h_q <= HASH_SEED;
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
      end
      ST_SRC_HS: begin
        start_code[k_q] <= h_next & mask_q;
        if (k_q == rmax_q) begin
          k_q <= '0;
          h_q <= HASH_SEED;
        end else begin
          k_q <= k_q + 2'd1;
          h_q <= h_next;
        end
      end
      ST_DST_RD: begin
        if (!in_range) begin
          t_code <= '0;
          j_q <= '0;
          sel_q <= 1'b0;
          h_q <= HASH_SEED;
        end
      end
      ST_DST_HS: begin
        if (k_q == r_q) begin
          t_code <= h_next & mask_q;
          j_q <= '0;
          sel_q <= 1'b0;
          h_q <= HASH_SEED;
        end else begin
          k_q <= k_q + 2'd1;
          h_q <= h_next;
        end
      end
      ST_TUP: begin
        h_q <= h_next;
        j_q <= j_q + 2'd1;
      end
      ST_EMIT: begin
        if (out_free) begin
          m_axis_tdata <= {3'd0, d_q, r_q, h_q & mask_q};
          m_axis_tuser <= sel_q;
          m_axis_tlast <= sel_q && pair_last;
          h_q <= HASH_SEED;
          j_q <= '0;
          k_q <= '0;
          sel_q <= !sel_q;
          if (sel_q) begin
            if (d_q == dmax_q) begin
              d_q <= '0;
              r_q <= r_q + 2'd1;
            end else begin
              d_q <= d_q + 3'd1;
            end
          end
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_last_ctx: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("last word is not a context-only word");
  a_dst_k: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DST_RD || state == ST_DST_HS) |-> k_q <= r_q)
    else $error("destination run passed its radius");
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !out_free) |=> state == ST_EMIT)
    else $error("emit left while output register was full");
`endif

endmodule

// ===== tb/tb_kmer_pair_feature_hasher.sv =====
// Self-checking testbench for the k-mer pair feature hasher with a built-in feature predictor.
module tb_kmer_pair_feature_hasher;
  import kpfh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] code;
    logic        ctx;
    logic [1:0]  rad;
    logic [2:0]  dindex;
    logic        lst;
  } feature_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  kmer_pair_feature_hasher uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [7:0]  seq_mem [MAX_LEN_DEF];
  logic [1:0]  rad_lim;
  logic [2:0]  dist_lim;
  logic [31:0] mask;
  feature_t    expected_features[$];
  int          errors = 0;
  int          hold_off = 0;
  bit          stall_on = 1'b1;

  function automatic logic [31:0] mix(logic [31:0] h, int idx, logic [31:0] v);
    if (idx % 2 == 0) return h ^ ((h << 7) ^ (v * (h >> 3)));
    return h ^ ~(((h << 11) + v) ^ (h >> 5));
  endfunction

  function automatic logic [31:0] prefix_code(int start, int len, int r);
    logic [31:0] h;
    h = HASH_SEED;
    if (start + r >= len) return 32'h0;
    for (int k = 0; k <= r; k++)
      h = mix(h, start + k, {{24{seq_mem[start + k][7]}}, seq_mem[start + k]});
    return h & mask;
  endfunction

  function automatic logic [31:0] tuple_code(logic [31:0] a, b, c, d);
    logic [31:0] h;
    h = mix(HASH_SEED, 0, a);
    h = mix(h, 1, b);
    h = mix(h, 2, c);
    return mix(h, 3, d) & mask;
  endfunction

  task automatic predict_query(int start, int len);
    logic [31:0] s, t, lo, hi;
    int dst;
    if (len > MAX_LEN_DEF) len = MAX_LEN_DEF;
    for (int r = 0; r <= rad_lim; r++) begin
      for (int d = 0; d <= dist_lim; d++) begin
        dst = start + d;
        if (len > 0 && dst > len - 1) dst = len - 1;
        s = prefix_code(start, len, r);
        t = prefix_code(dst, len, r);
        lo = (s < t) ? s : t;
        hi = (s < t) ? t : s;
        expected_features.insert(expected_features.size(),
                                 {tuple_code(r, d, lo, hi), 1'b0, 2'(r), 3'(d), 1'b0});
        expected_features.insert(expected_features.size(),
                                 {tuple_code(r, d, 0, t), 1'b1, 2'(r), 3'(d),
                                  1'(r == rad_lim && d == dist_lim)});
      end
    end
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_word(logic op, logic [9:0] pos, logic [7:0] ch, logic [10:0] len);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {3'b0, len, ch, pos};
    do @(posedge clk); while (!s_axis_tready);
    if (op == OP_WRITE) begin
      seq_mem[pos] = ch;
    end else begin
      predict_query(pos, len);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_RADIUS:   rad_lim = val[1:0];
      REG_DISTANCE: dist_lim = val[2:0];
      REG_MASK:     mask = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_features.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_config(logic [1:0] r, logic [2:0] d, logic [31:0] m);
    drain();
    write_reg(REG_RADIUS, r);
    write_reg(REG_DISTANCE, d);
    write_reg(REG_MASK, m);
  endtask

  // Queries stay within the written regions so that no unwritten entry is read.
  task automatic random_query();
    int len;
    len = $urandom_range(1, 40);
    if ($urandom_range(0, 15) == 0) len = $urandom_range(1025, 2047);
    if ($urandom_range(0, 15) == 0) len = 0;
    send_word(OP_QUERY, 10'($urandom_range(0, 50)), 8'($urandom), 11'(len));
  endtask

  task automatic test_fill_sequence();
    int p;
    for (int i = 0; i < 88; i++) begin
      p = (i < 64) ? i : ((i < 80) ? 448 + i : 936 + i);
      send_word(OP_WRITE, 10'(p), 8'($urandom), 11'($urandom));
      if (i % 16 == 0) idle_gap();
    end
    send_word(OP_WRITE, 10'd0, 8'h80, 11'h7FF);
    send_word(OP_WRITE, 10'd1, 8'h7F, 11'h000);
    send_word(OP_WRITE, 10'd2, 8'hFF, 11'h555);
    send_word(OP_WRITE, 10'd1023, 8'h00, 11'h2AA);
  endtask

  task automatic test_directed_queries();
    set_config(2'd0, 3'd0, MASK_RESET);
    send_word(OP_QUERY, 10'd0, 8'h00, 11'd1);
    set_config(2'd3, 3'd7, 32'hFFFFFFFF);
    send_word(OP_QUERY, 10'd0, 8'hFF, 11'd1024);
    send_word(OP_QUERY, 10'd1023, 8'h00, 11'd1024);
    send_word(OP_QUERY, 10'd1020, 8'h00, 11'd1024);
    send_word(OP_QUERY, 10'd5, 8'h00, 11'd0);
    send_word(OP_QUERY, 10'd30, 8'h00, 11'd10);
    send_word(OP_QUERY, 10'd3, 8'h00, 11'd2047);
    send_word(OP_QUERY, 10'd2, 8'h00, 11'd4);
    set_config(2'd1, 3'd2, 32'h0);
    send_word(OP_QUERY, 10'd7, 8'h00, 11'd12);
    set_config(2'd2, 3'd5, 32'h0000FFFF);
    send_word(OP_QUERY, 10'd512, 8'h00, 11'd600);
  endtask

  task automatic test_output_backpressure();
    set_config(2'd3, 3'd7, 32'hFFFFFFFF);
    hold_off = 400;
    for (int i = 0; i < 4; i++) send_word(OP_QUERY, 10'(i * 3), 8'h00, 11'd30);
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 5; ph++) begin
      set_config(2'($urandom), 3'($urandom), (ph == 0) ? 32'hFFFFFFFF : $urandom);
      for (int i = 0; i < 72; i++) begin
        if ($urandom_range(0, 2) == 0)
          send_word(OP_WRITE, 10'($urandom), 8'($urandom), 11'($urandom));
        else
          random_query();
        idle_gap();
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_on) begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    feature_t got, exp_f;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[33:32], m_axis_tdata[36:34],
             m_axis_tlast};
      if (expected_features.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
      end else begin
        exp_f = expected_features.pop_front();
        if (got.code !== exp_f.code || got.ctx !== exp_f.ctx || got.rad !== exp_f.rad ||
            got.dindex !== exp_f.dindex || got.lst !== exp_f.lst ||
            m_axis_tdata[39:37] !== 3'b0) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_f, got);
          errors++;
        end
      end
    end
  end

  initial begin
    rad_lim = 2'd0;
    dist_lim = 3'd0;
    mask = MASK_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_sequence();
    test_directed_queries();
    test_output_backpressure();
    test_random_traffic();
    stall_on = 1'b0;
    set_config(2'd0, 3'd0, MASK_RESET);
    drain();
    if (errors == 0 && expected_features.size() == 0) begin
      $display("kmer_pair_feature_hasher test passed");
    end else begin
      $display("kmer_pair_feature_hasher test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("kmer_pair_feature_hasher test failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
src/kpfh_pkg.sv
src/kpfh_seq_mem.sv
src/kpfh_cfg.sv
src/kmer_pair_feature_hasher.sv
tb/tb_kmer_pair_feature_hasher.sv
